// ----- rtl/upu_pkg.sv -----
// Shared types, codes and constants for the URI percent unescape unit.
package upu_pkg;

   localparam logic [7:0] PCT_CHAR  = 8'h25;
   localparam logic [7:0] ASCII_MAX = 8'h7F;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_FORBID_ASCII = 2'd0,
      REG_ILLEGAL_A    = 2'd1,
      REG_ILLEGAL_B    = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_HEX   = 3'd1,
      ST_ESC_ASCII = 3'd2,
      ST_ILLEGAL   = 3'd3,
      ST_TRUNC     = 3'd4,
      ST_BAD_UTF8  = 3'd5
   } status_type;

   // continuation byte range for the byte right after a lead byte
   typedef enum logic [2:0] {
      RC_ANY   = 3'd0,  // 80-BF
      RC_A0_BF = 3'd1,
      RC_80_9F = 3'd2,
      RC_90_BF = 3'd3,
      RC_80_8F = 3'd4
   } range_class_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HIGH = 3'b010,
      PH_LOW  = 3'b100
   } phase_type;

   // one classified input beat
   typedef struct packed {
      logic [7:0] raw;
      logic       last;
      logic       is_pct;
      logic       hex_ok;
      logic [3:0] hex_val;
   } class_type;

   typedef struct packed {
      logic       forbid_ascii;
      logic [7:0] illegal_a;
      logic [7:0] illegal_b;
   } cfg_type;

endpackage

// ----- rtl/upu_front.sv -----
// Front end: classifies each raw byte (percent sign, hex digit and its value).
module upu_front (
   input  logic              req_valid,
   input  logic [7:0]        req_in_byte,
   input  logic              req_is_last,
   input  logic              queue_full,
   output logic              req_stall,
   output logic              push,
   output upu_pkg::class_type push_data
);
   import upu_pkg::*;

   logic       hex_ok;
   logic [3:0] hex_val;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (req_in_byte >= 8'h30 && req_in_byte <= 8'h39) begin
         hex_val = req_in_byte[3:0];
      end else if ((req_in_byte >= 8'h41 && req_in_byte <= 8'h46) ||
                   (req_in_byte >= 8'h61 && req_in_byte <= 8'h66)) begin
         hex_val = req_in_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign push_data.raw     = req_in_byte;
   assign push_data.last    = req_is_last;
   assign push_data.is_pct  = (req_in_byte == PCT_CHAR);
   assign push_data.hex_ok  = hex_ok;
   assign push_data.hex_val = hex_val;

endmodule

// ----- rtl/upu_queue.sv -----
// Small flop queue of classified beats between front and back.
module upu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  upu_pkg::class_type push_data,
   input  logic               pop,
   output upu_pkg::class_type pop_data,
   output logic               not_empty,
   output logic               full
);
   import upu_pkg::*;

   class_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/upu_back.sv -----
// Back end: escape decode, UTF-8 check, end status and the result register.
module upu_back (
   input  logic               clock,
   input  logic               reset,
   input  upu_pkg::cfg_type   cfg,
   input  logic               not_empty,
   input  upu_pkg::class_type item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_out_valid,
   output logic               rsp_end_mark,
   output logic [2:0]         rsp_status
);
   import upu_pkg::*;

   phase_type       phase_ff,  phase_in;
   logic [3:0]      nibble_ff, nibble_in;
   status_type      esc_ff,    esc_in;
   logic [1:0]      pend_ff,   pend_in;
   range_class_type rc_ff,     rc_in;
   logic            uerr_ff,   uerr_in;
   logic            zero_ff,   zero_in;

   logic            rsp_valid_ff;
   logic [7:0]      out_byte_ff;
   logic            out_valid_ff, end_mark_ff;
   status_type      status_ff;

   logic [7:0]      ob, code, lo, hi;
   logic            ov;
   status_type      st;

   assign pop = not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_in  = phase_ff;
      nibble_in = nibble_ff;
      esc_in    = esc_ff;
      pend_in   = pend_ff;
      rc_in     = rc_ff;
      uerr_in   = uerr_ff;
      zero_in   = zero_ff;
      ob        = 8'd0;
      ov        = 1'b0;
      st        = ST_OK;
      code      = {nibble_ff, item.hex_val};
      lo        = 8'h80;
      hi        = 8'hBF;

      if (esc_ff == ST_OK) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (item.is_pct) begin
                  phase_in = PH_HIGH;
                  if (item.last) esc_in = ST_TRUNC;
               end else begin
                  ob = item.raw;
                  ov = 1'b1;
               end
            end
            PH_HIGH: begin
               if (item.last) begin
                  esc_in = ST_TRUNC;
               end else if (!item.hex_ok) begin
                  esc_in = ST_BAD_HEX;
               end else begin
                  nibble_in = item.hex_val;
                  phase_in  = PH_LOW;
               end
            end
            PH_LOW: begin
               phase_in = PH_IDLE;
               if (!item.hex_ok || code == 8'd0) begin
                  esc_in = ST_BAD_HEX;
               end else if (cfg.forbid_ascii && code <= ASCII_MAX) begin
                  esc_in = ST_ESC_ASCII;
               end else if ((cfg.illegal_a != 8'd0 && code == cfg.illegal_a) ||
                            (cfg.illegal_b != 8'd0 && code == cfg.illegal_b)) begin
                  esc_in = ST_ILLEGAL;
               end else begin
                  ob = code;
                  ov = 1'b1;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      // strict UTF-8 on the decoded byte
      if (ov && !uerr_ff && !zero_ff) begin
         if (pend_ff != 2'd0) begin
            case (rc_ff)
               RC_A0_BF: lo = 8'hA0;
               RC_80_9F: hi = 8'h9F;
               RC_90_BF: lo = 8'h90;
               RC_80_8F: hi = 8'h8F;
               default:  ;
            endcase
            if (ob < lo || ob > hi) begin
               uerr_in = 1'b1;
            end else begin
               rc_in   = RC_ANY;
               pend_in = pend_ff - 2'd1;
            end
         end else if (ob == 8'd0) begin
            zero_in = 1'b1;
         end else if (ob <= ASCII_MAX) begin
            // plain ASCII
         end else if (ob >= 8'hC2 && ob <= 8'hDF) begin
            pend_in = 2'd1; rc_in = RC_ANY;
         end else if (ob == 8'hE0) begin
            pend_in = 2'd2; rc_in = RC_A0_BF;
         end else if (ob == 8'hED) begin
            pend_in = 2'd2; rc_in = RC_80_9F;
         end else if (ob >= 8'hE1 && ob <= 8'hEF) begin
            pend_in = 2'd2; rc_in = RC_ANY;
         end else if (ob == 8'hF0) begin
            pend_in = 2'd3; rc_in = RC_90_BF;
         end else if (ob == 8'hF4) begin
            pend_in = 2'd3; rc_in = RC_80_8F;
         end else if (ob >= 8'hF1 && ob <= 8'hF3) begin
            pend_in = 2'd3; rc_in = RC_ANY;
         end else begin
            uerr_in = 1'b1;
         end
      end

      if (item.last) begin
         if (esc_in != ST_OK) begin
            st = esc_in;
         end else if (uerr_in || (!zero_in && pend_in != 2'd0)) begin
            st = ST_BAD_UTF8;
         end
         phase_in  = PH_IDLE;
         nibble_in = 4'd0;
         esc_in    = ST_OK;
         pend_in   = 2'd0;
         rc_in     = RC_ANY;
         uerr_in   = 1'b0;
         zero_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         nibble_ff    <= 4'd0;
         esc_ff       <= ST_OK;
         pend_ff      <= 2'd0;
         rc_ff        <= RC_ANY;
         uerr_ff      <= 1'b0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff  <= phase_in;
            nibble_ff <= nibble_in;
            esc_ff    <= esc_in;
            pend_ff   <= pend_in;
            rc_ff     <= rc_in;
            uerr_ff   <= uerr_in;
            zero_ff   <= zero_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_byte_ff  <= ob;
         out_valid_ff <= ov;
         end_mark_ff  <= item.last;
         status_ff    <= st;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_out_valid = out_valid_ff;
   assign rsp_end_mark  = end_mark_ff;
   assign rsp_status    = status_ff;

endmodule

// ----- rtl/uri_percent_unescape_unit.sv -----
// Top level of the URI percent unescape unit: CSRs, front, queue and back.
//
//   channel | direction | beat contents                        | handshake
//   --------+-----------+--------------------------------------+------------------
//   req     | in        | in_byte, is_last                     | req_valid/stall
//   rsp     | out       | out_byte, out_valid, end_mark, status| rsp_valid/stall
//   csr     | in/out    | 3 regs at byte offsets 0, 4, 8       | APB, pready = 1
//
// One byte per cycle sustained while rsp_stall is low; the back end's per-byte
// state update sets that rate. A request beat lands in the 4-entry queue when
// accepted; the back end pops it and writes its result into the result register,
// which drives rsp, and the result beat is taken when rsp_valid is high and rsp_stall low.
// Synchronous active-high reset clears the queue, the decode state, the result
// valid flag and the CSRs. rsp_stall holds the result register; the queue keeps
// taking beats until it fills, then req_stall rises.
module uri_percent_unescape_unit (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_in_byte,
   input  logic                           req_is_last,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_out_valid,
   output logic                           rsp_end_mark,
   output logic [2:0]                     rsp_status,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [upu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import upu_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_idx;
   logic          csr_write;

   logic          queue_full, queue_not_empty;
   logic          push, pop;
   class_type     push_data, pop_data;

   // CSR block; word index from the byte address
   assign pready    = 1'b1;
   assign reg_idx   = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_FORBID_ASCII: cfg_ff.forbid_ascii <= pwdata[0];
            REG_ILLEGAL_A:    cfg_ff.illegal_a    <= pwdata[7:0];
            REG_ILLEGAL_B:    cfg_ff.illegal_b    <= pwdata[7:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      unique case (reg_idx)
         REG_FORBID_ASCII: prdata = {31'd0, cfg_ff.forbid_ascii};
         REG_ILLEGAL_A:    prdata = {24'd0, cfg_ff.illegal_a};
         REG_ILLEGAL_B:    prdata = {24'd0, cfg_ff.illegal_b};
         default:          prdata = 32'd0;
      endcase
   end

   // front: classify each byte on the way in
   upu_front u_front (
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_is_last (req_is_last),
      .queue_full  (queue_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_data   (push_data)
   );

   // decouples request accept from result stalls
   upu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // back: stream state, status and result register
   upu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .not_empty     (queue_not_empty),
      .item          (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_end_mark  (rsp_end_mark),
      .rsp_status    (rsp_status)
   );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the URI percent unescape unit with UTF-8 status checks.
module tb;
   import upu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any port
   localparam int TAIL_CYCLES    = 8;     // idle wait after the last expected result beat is checked
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_BYTES    = 160;

   // one predicted result beat
   typedef struct {
      logic [7:0] data;
      logic       data_valid;
      logic       end_mark;
      status_type status;
   } decoded_beat_t;

   // Predicts the decoder byte by byte and checks result beats in order.
   class unescape_scoreboard;
      bit              forbid_ascii;
      logic [7:0]      illegal_a;
      logic [7:0]      illegal_b;
      phase_type       phase;
      logic [3:0]      high_nib;
      status_type      esc_err;     // ST_OK while no escape error
      int unsigned     cont_left;   // UTF-8 continuation bytes still owed
      range_class_type cont_range;
      bit              utf8_bad;
      bit              zero_hit;    // raw zero seen, UTF-8 check off
      decoded_beat_t   due_beats[$];
      int unsigned     failures;
      int unsigned     end_tally[8];

      function new();
         forbid_ascii = 1'b0;
         illegal_a    = 8'h00;
         illegal_b    = 8'h00;
         failures     = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         phase      = PH_IDLE;
         high_nib   = 4'h0;
         esc_err    = ST_OK;
         cont_left  = 0;
         cont_range = RC_ANY;
         utf8_bad   = 1'b0;
         zero_hit   = 1'b0;
      endfunction

      function bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
         v = 4'h0;
         if (b >= 8'h30 && b <= 8'h39) v = 4'(b - 8'h30);
         else if (b >= 8'h41 && b <= 8'h46) v = 4'(b - 8'h41 + 8'd10);
         else if (b >= 8'h61 && b <= 8'h66) v = 4'(b - 8'h61 + 8'd10);
         else return 1'b0;
         return 1'b1;
      endfunction

      function void feed_utf8(logic [7:0] b);
         logic [7:0] lo;
         logic [7:0] hi;
         if (utf8_bad || zero_hit) return;
         if (cont_left != 0) begin
            lo = 8'h80;
            hi = 8'hBF;
            case (cont_range)
               RC_A0_BF: lo = 8'hA0;
               RC_80_9F: hi = 8'h9F;
               RC_90_BF: lo = 8'h90;
               RC_80_8F: hi = 8'h8F;
               default: ;
            endcase
            if (b < lo || b > hi) begin
               utf8_bad = 1'b1;
               return;
            end
            cont_range = RC_ANY;
            cont_left--;
            return;
         end
         if (b == 8'h00) zero_hit = 1'b1;
         else if (b > ASCII_MAX) begin
            if (b >= 8'hC2 && b <= 8'hDF) begin
               cont_left = 1; cont_range = RC_ANY;
            end else if (b == 8'hE0) begin
               cont_left = 2; cont_range = RC_A0_BF;
            end else if (b == 8'hED) begin
               cont_left = 2; cont_range = RC_80_9F;
            end else if (b >= 8'hE1 && b <= 8'hEF) begin
               cont_left = 2; cont_range = RC_ANY;
            end else if (b == 8'hF0) begin
               cont_left = 3; cont_range = RC_90_BF;
            end else if (b == 8'hF4) begin
               cont_left = 3; cont_range = RC_80_8F;
            end else if (b >= 8'hF1 && b <= 8'hF3) begin
               cont_left = 3; cont_range = RC_ANY;
            end else utf8_bad = 1'b1;
         end
      endfunction

      // accepted request beat: work out its result
      function void note_request(logic [7:0] b, logic last);
         decoded_beat_t r;
         logic [3:0]    nib;
         logic [7:0]    c;
         bit            ok;
         r.data       = 8'h00;
         r.data_valid = 1'b0;
         r.end_mark   = last;
         r.status     = ST_OK;
         if (esc_err == ST_OK) begin
            case (phase)
               PH_IDLE: begin
                  if (b == PCT_CHAR) begin
                     phase = PH_HIGH;
                     if (last) esc_err = ST_TRUNC;
                  end else begin
                     r.data       = b;
                     r.data_valid = 1'b1;
                  end
               end
               PH_HIGH: begin
                  ok = hex_nibble(b, nib);
                  if (last) esc_err = ST_TRUNC;
                  else if (!ok) esc_err = ST_BAD_HEX;
                  else begin
                     high_nib = nib;
                     phase    = PH_LOW;
                  end
               end
               default: begin
                  phase = PH_IDLE;
                  ok    = hex_nibble(b, nib);
                  c     = {high_nib, nib};
                  if (!ok || c == 8'h00) esc_err = ST_BAD_HEX;
                  else if (forbid_ascii && c <= ASCII_MAX) esc_err = ST_ESC_ASCII;
                  else if ((illegal_a != 8'h00 && c == illegal_a) ||
                           (illegal_b != 8'h00 && c == illegal_b)) esc_err = ST_ILLEGAL;
                  else begin
                     r.data       = c;
                     r.data_valid = 1'b1;
                  end
               end
            endcase
            if (r.data_valid) feed_utf8(r.data);
         end
         if (last) begin
            if (esc_err != ST_OK) r.status = esc_err;
            else if (utf8_bad || (!zero_hit && cont_left != 0)) r.status = ST_BAD_UTF8;
            end_tally[r.status]++;
            clear_stream();
         end
         due_beats.push_back(r);
      endfunction

      function void check_response(logic [7:0] data, logic dv, logic em, logic [2:0] st);
         decoded_beat_t e;
         if (due_beats.size() == 0) begin
            $error("result beat with nothing pending: out_byte %h end_mark %b", data, em);
            failures++;
            return;
         end
         e = due_beats.pop_front();
         if (data !== e.data) begin
            $error("out_byte: expected %h, got %h", e.data, data);
            failures++;
         end
         if (dv !== e.data_valid) begin
            $error("out_valid: expected %b, got %b", e.data_valid, dv);
            failures++;
         end
         if (em !== e.end_mark) begin
            $error("end_mark: expected %b, got %b", e.end_mark, em);
            failures++;
         end
         if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            failures++;
         end
      endfunction

      function int outstanding();
         return due_beats.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_in_byte   = 8'h00;
   logic                  req_is_last   = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_out_valid;
   logic                  rsp_end_mark;
   logic [2:0]            rsp_status;
   logic                  psel          = 1'b0;
   logic                  penable       = 1'b0;
   logic                  pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr         = '0;
   logic [31:0]           pwdata        = 32'd0;
   logic [31:0]           prdata;
   logic                  pready;

   unescape_scoreboard sb = new();

   logic [7:0]  plain_text[$];  // decoded text of the next string
   logic [7:0]  wire_text[$];   // escaped bytes as sent
   bit          tail_quiet   = 1'b0;  // no gaps or stalls in the last phase
   int unsigned gap_calm     = 0;
   int unsigned bytes_sent   = 0;
   int unsigned strings_sent = 0;
   int unsigned settings_run = 0;
   int unsigned csr_failures = 0;
   int unsigned idle_run     = 0;

   uri_percent_unescape_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_end_mark  (rsp_end_mark),
      .rsp_status    (rsp_status),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- text generation

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return 8'h30 + v;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
   endfunction

   // first continuation byte allowed after a lead byte (strict UTF-8)
   function automatic logic [7:0] first_follow(logic [7:0] lead);
      case (lead)
         8'hE0:   return 8'($urandom_range(8'hA0, 8'hBF));
         8'hED:   return 8'($urandom_range(8'h80, 8'h9F));
         8'hF0:   return 8'($urandom_range(8'h90, 8'hBF));
         8'hF4:   return 8'($urandom_range(8'h80, 8'h8F));
         default: return 8'($urandom_range(8'h80, 8'hBF));
      endcase
   endfunction

   function automatic void add_code_point();
      logic [7:0]  lead;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) plain_text.push_back(8'($urandom_range(1, 127)));
      else if (kind < 6) begin
         plain_text.push_back(8'($urandom_range(8'hC2, 8'hDF)));
         plain_text.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 8) begin
         lead = 8'($urandom_range(8'hE0, 8'hEF));
         plain_text.push_back(lead);
         plain_text.push_back(first_follow(lead));
         plain_text.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 9) begin
         lead = 8'($urandom_range(8'hF0, 8'hF4));
         plain_text.push_back(lead);
         plain_text.push_back(first_follow(lead));
         repeat (2) plain_text.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
         // a literal percent sign, or now and then a raw zero
         plain_text.push_back($urandom_range(0, 4) == 0 ? 8'h00 : PCT_CHAR);
      end
   endfunction

   // high bytes escaped more often than ASCII; '%' always escaped, zero never
   function automatic void escape_text();
      logic [7:0] b;
      wire_text.delete();
      foreach (plain_text[i]) begin
         b = plain_text[i];
         if (b != 8'h00 && (b == PCT_CHAR || $urandom_range(0, b[7] ? 2 : 5) == 0)) begin
            wire_text.push_back(PCT_CHAR);
            wire_text.push_back(hex_char(b[7:4]));
            wire_text.push_back(hex_char(b[3:0]));
         end else wire_text.push_back(b);
      end
   endfunction

   function automatic void damage_text(logic [7:0] ill_a, logic [7:0] ill_b);
      int unsigned pos;
      logic [7:0]  v;
      pos = $urandom_range(0, wire_text.size() - 1);
      case ($urandom_range(0, 5))
         0: wire_text[pos] = 8'($urandom);
         1: while (wire_text.size() > pos + 1) void'(wire_text.pop_back());
         2: begin
            // escape cut off by the end of the string
            wire_text.push_back(PCT_CHAR);
            if ($urandom_range(0, 1)) wire_text.push_back(hex_char(4'($urandom)));
         end
         3: begin
            wire_text.insert(pos, PCT_CHAR);
            wire_text.insert(pos + 1, 8'($urandom));
            wire_text.insert(pos + 2, 8'($urandom));
         end
         4: begin
            v = $urandom_range(0, 1) ? ill_a : ill_b;
            wire_text.insert(pos, PCT_CHAR);
            wire_text.insert(pos + 1, hex_char(v[7:4]));
            wire_text.insert(pos + 2, hex_char(v[3:0]));
         end
         default: repeat ($urandom_range(1, 4)) wire_text.insert(pos, 8'($urandom));
      endcase
   endfunction

   // ---------------------------------------------------------------- drivers

   // one request beat; gaps come in bursts separated by calm stretches
   task automatic send_byte(logic [7:0] b, logic last);
      if (gap_calm > 0) gap_calm--;
      else if (!tail_quiet) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         gap_calm = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(10, 60);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_is_last <= last;
      do @(posedge clock); while (req_stall);
      sb.note_request(b, last);
      bytes_sent++;
   endtask

   task automatic send_wire();
      foreach (wire_text[i]) send_byte(wire_text[i], i == wire_text.size() - 1);
      strings_sent++;
   endtask

   task automatic send_text(string s);
      wire_text.delete();
      for (int i = 0; i < s.len(); i++) wire_text.push_back(s[i]);
      send_wire();
   endtask

   // setup cycle then access cycle; the caller drops psel after its last access
   task automatic csr_access(logic wr, reg_index_type idx, logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   // registers change only with the pipe empty
   task automatic apply_settings(bit f, logic [7:0] a, logic [7:0] b);
      logic [31:0] rd;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      csr_access(1'b1, REG_FORBID_ASCII, {31'd0, f}, rd);
      csr_access(1'b1, REG_ILLEGAL_A, {24'd0, a}, rd);
      csr_access(1'b1, REG_ILLEGAL_B, {24'd0, b}, rd);
      sb.forbid_ascii = f;
      sb.illegal_a    = a;
      sb.illegal_b    = b;
      csr_access(1'b0, REG_FORBID_ASCII, 32'd0, rd);
      if (rd[0] !== f) begin
         $error("forbid_escaped_ascii readback: expected %b, got %b", f, rd[0]);
         csr_failures++;
      end
      csr_access(1'b0, REG_ILLEGAL_A, 32'd0, rd);
      if (rd[7:0] !== a) begin
         $error("illegal_char_a readback: expected %h, got %h", a, rd[7:0]);
         csr_failures++;
      end
      csr_access(1'b0, REG_ILLEGAL_B, 32'd0, rd);
      if (rd[7:0] !== b) begin
         $error("illegal_char_b readback: expected %h, got %h", b, rd[7:0]);
         csr_failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_run++;
   endtask

   // ---------------------------------------------------------------- result side

   // Checks every accepted result beat. Stall comes in bursts, each followed by
   // a calm stretch, short or long.
   initial begin
      int unsigned hold;
      int unsigned calm;
      hold = 0;
      calm = 20;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_response(rsp_out_byte, rsp_out_valid, rsp_end_mark, rsp_status);
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (calm > 0) calm--;
            else if (!tail_quiet) begin
               hold = $urandom_range(1, 12);
               calm = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(20, 80);
            end
         end
      end
   end

   // watchdog: any beat on either channel, or CSR traffic, counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_run <= 0;
      else begin
         idle_run <= idle_run + 1;
         if (idle_run >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      int unsigned budget;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed strings at reset settings
      send_text("%41");        // escape to plain ASCII
      send_text("%c3%A9");     // two-byte character, both hex cases
      send_text("%00");        // escape to zero
      send_text("%G1");        // bad hex digit; trailing byte ignored
      send_text("%");          // escape cut off right after the percent sign
      send_text("%Z");         // cut off on first digit position, non-hex
      wire_text = '{8'hED, 8'hA0, 8'h80};   // surrogate
      send_wire();
      wire_text = '{8'h00, 8'hFF};          // raw zero ends the UTF-8 check
      send_wire();
      wire_text = '{8'hE2};                 // sequence left open at the end
      send_wire();
      wire_text = '{8'hF4, 8'h90, 8'h80, 8'h80};  // above U+10FFFF
      send_wire();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            req_valid <= 1'b0;
            case (p)
               1: apply_settings(1'b1, 8'hFF, 8'h01);
               2: apply_settings(1'b0, 8'hA9, 8'hFF);
               3: apply_settings(1'b0, 8'h80, 8'hC3);
               4: apply_settings(1'($urandom), 8'($urandom_range(8'h80, 8'hF4)),
                                 8'($urandom));
               default: apply_settings(1'b0, 8'h00, 8'h00);
            endcase
            if (p == NUM_PHASES - 1) tail_quiet = 1'b1;
            send_text("%41");
            send_text("%c3%A9");
         end
         budget = bytes_sent + PHASE_BYTES;
         while (bytes_sent < budget) begin
            plain_text.delete();
            repeat ($urandom_range(1, 8)) add_code_point();
            escape_text();
            if ($urandom_range(0, 3) == 0) damage_text(sb.illegal_a, sb.illegal_b);
            send_wire();
         end
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d strings, %0d bytes, across %0d register settings after reset",
               strings_sent, bytes_sent, settings_run);
      $display({"End status: ok %0d, bad hex %0d, escaped ascii %0d, illegal %0d, ",
                "truncated %0d, bad utf8 %0d"},
               sb.end_tally[ST_OK], sb.end_tally[ST_BAD_HEX], sb.end_tally[ST_ESC_ASCII],
               sb.end_tally[ST_ILLEGAL], sb.end_tally[ST_TRUNC], sb.end_tally[ST_BAD_UTF8]);
      if (sb.failures == 0 && csr_failures == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
